// ----- sv/button_gesture_debouncer_core_macros.svh -----
// ---------------------------------------------------------------------------
// Button gesture debouncer - assertion macros
// Concurrent checks clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DEBOUNCER_CORE_MACROS_SVH
`define BUTTON_GESTURE_DEBOUNCER_CORE_MACROS_SVH

// same-cycle implication
`define BGD_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgd check failed");

// next-cycle implication
`define BGD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgd check failed");

`endif

// ----- sv/bgd_pkg.sv -----
// ---------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture debouncer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgd_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CFG_W    = 16;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned ADDR_W   = 4;

   localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd30;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd800;
   localparam logic [CFG_W-1:0] SERVICE_HOLD_RST = 16'd5000;
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd350;

   typedef enum logic [1:0] {
      REG_DEBOUNCE     = 2'd0,
      REG_LONG_PRESS   = 2'd1,
      REG_SERVICE_HOLD = 2'd2,
      REG_DOUBLE_CLICK = 2'd3
   } bgd_reg_type;

   typedef struct packed {
      logic changed;
      logic level;
   } bgd_deb_type;

   typedef struct packed {
      logic single_click;
      logic double_click;
      logic long_press;
      logic service_hold;
   } bgd_click_type;

endpackage

// ----- sv/button_gesture_debouncer_core.sv -----
// Button gesture debouncer.
// Request channel (req_*): one poll per request, a millisecond timestamp and
// the raw active-low button and blade levels. Response channel (rsp_*): one
// result per request, six event flags, in request order.
// A request is registered, evaluated against the held debounce and gesture
// state in one pass, and its result registered; rsp_valid rises when the
// result register loads. One request per cycle is sustained while rsp_ready
// stays high; the rate is set by the single registered evaluation stage.
// When the receiver stalls, the result register holds and the input register
// holds behind it; req_ready drops only while both are full.
// Reset clears both stages, returns every level to released or absent, drops
// any pending click and restores the timing registers to their defaults.
// Timing registers sit on the APB-style port at byte addresses 0, 4, 8, 12;
// write them only while no request is in flight.
// ---------------------------------------------------------------------------
// button_gesture_debouncer_core
// Top level: input register, debouncers, gesture logic, result register, CSRs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_gesture_debouncer_core_macros.svh"

module button_gesture_debouncer_core
   import bgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic              req_button_level,
   input  logic              req_blade_level,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_blade_inserted,
   output logic              rsp_blade_removed,
   output logic              rsp_single_click,
   output logic              rsp_double_click,
   output logic              rsp_long_press,
   output logic              rsp_service_hold,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   logic [CFG_W-1:0]  debounce_ff;
   logic [CFG_W-1:0]  long_press_ff;
   logic [CFG_W-1:0]  service_hold_ff;
   logic [CFG_W-1:0]  double_click_ff;
   logic              csr_write;
   bgd_reg_type       csr_index;

   logic              in_valid_ff;
   logic [TIME_W-1:0] in_now_ff;
   logic              in_button_ff;
   logic              in_blade_ff;
   logic              advance;

   bgd_deb_type       blade_deb;
   bgd_deb_type       button_deb;
   bgd_click_type     clicks;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic              inserted_ff;
   logic              removed_ff;
   bgd_click_type     clicks_ff;

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = bgd_reg_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      case (csr_index)
         REG_DEBOUNCE:     prdata = {{(CSR_W-CFG_W){1'b0}}, debounce_ff};
         REG_LONG_PRESS:   prdata = {{(CSR_W-CFG_W){1'b0}}, long_press_ff};
         REG_SERVICE_HOLD: prdata = {{(CSR_W-CFG_W){1'b0}}, service_hold_ff};
         REG_DOUBLE_CLICK: prdata = {{(CSR_W-CFG_W){1'b0}}, double_click_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RST;
         long_press_ff   <= LONG_PRESS_RST;
         service_hold_ff <= SERVICE_HOLD_RST;
         double_click_ff <= DOUBLE_CLICK_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE:     debounce_ff     <= pwdata[CFG_W-1:0];
            REG_LONG_PRESS:   long_press_ff   <= pwdata[CFG_W-1:0];
            REG_SERVICE_HOLD: service_hold_ff <= pwdata[CFG_W-1:0];
            REG_DOUBLE_CLICK: double_click_ff <= pwdata[CFG_W-1:0];
            default:          debounce_ff     <= debounce_ff;
         endcase
      end
   end

   // input register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff    <= req_now_ms;
         in_button_ff <= req_button_level;
         in_blade_ff  <= req_blade_level;
      end
   end

   // evaluation
   bgd_debounce u_blade_deb (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .now_ms      (in_now_ff),
      .raw         (in_blade_ff),
      .debounce_ms (debounce_ff),
      .deb         (blade_deb)
   );

   bgd_debounce u_button_deb (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .now_ms      (in_now_ff),
      .raw         (in_button_ff),
      .debounce_ms (debounce_ff),
      .deb         (button_deb)
   );

   bgd_gesture u_gesture (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .now_ms          (in_now_ff),
      .button          (button_deb),
      .long_press_ms   (long_press_ff),
      .service_min_ms  (service_hold_ff),
      .click_window_ms (double_click_ff),
      .events          (clicks)
   );

   // result register
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inserted_ff <= blade_deb.changed && !blade_deb.level;
         removed_ff  <= blade_deb.changed && blade_deb.level;
         clicks_ff   <= clicks;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_blade_inserted = inserted_ff;
   assign rsp_blade_removed  = removed_ff;
   assign rsp_single_click   = clicks_ff.single_click;
   assign rsp_double_click   = clicks_ff.double_click;
   assign rsp_long_press     = clicks_ff.long_press;
   assign rsp_service_hold   = clicks_ff.service_hold;

   // checks
   `BGD_ASSERT_IMPLY(a_stall_only_when_full, !req_ready, in_valid_ff && out_valid_ff && !rsp_ready)
   `BGD_ASSERT_IMPLY(a_blade_one_edge, rsp_valid, !(rsp_blade_inserted && rsp_blade_removed))
   `BGD_ASSERT_IMPLY(a_release_one_kind, rsp_valid && (rsp_service_hold || rsp_long_press), !rsp_single_click && !rsp_double_click)
   `BGD_ASSERT_IMPLY(a_double_no_single, rsp_valid && rsp_double_click, !rsp_single_click && !rsp_long_press)
   `BGD_ASSERT_NEXT(a_advance_loads_result, advance, out_valid_ff)

endmodule

// ----- sv/bgd_debounce.sv -----
// ---------------------------------------------------------------------------
// bgd_debounce
// Debounces one active-low level against a wrapping millisecond timestamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgd_debounce
   import bgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              raw,
   input  logic [CFG_W-1:0]  debounce_ms,
   output bgd_deb_type       deb
);

   logic              last_raw_ff;
   logic              stable_ff;
   logic [TIME_W-1:0] change_time_ff;
   logic [TIME_W-1:0] change_time_in;
   logic [TIME_W-1:0] elapsed;

   assign change_time_in = (raw != last_raw_ff) ? now_ms : change_time_ff;
   assign elapsed        = now_ms - change_time_in;

   always_comb begin
      deb.changed = (raw != stable_ff) &&
                    (elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
      deb.level   = deb.changed ? raw : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
      end else if (advance) begin
         last_raw_ff    <= raw;
         stable_ff      <= deb.level;
         change_time_ff <= change_time_in;
      end
   end

endmodule

// ----- sv/bgd_gesture.sv -----
// ---------------------------------------------------------------------------
// bgd_gesture
// Classifies debounced releases into click, double click, long press and
// service hold; holds back single clicks until the window has passed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgd_gesture
   import bgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [TIME_W-1:0] now_ms,
   input  bgd_deb_type       button,
   input  logic [CFG_W-1:0]  long_press_ms,
   input  logic [CFG_W-1:0]  service_min_ms,
   input  logic [CFG_W-1:0]  click_window_ms,
   output bgd_click_type     events
);

   logic [TIME_W-1:0] press_start_ff;
   logic [TIME_W-1:0] press_start_in;
   logic              click_pending_ff;
   logic              click_pending_in;
   logic [TIME_W-1:0] click_time_ff;
   logic [TIME_W-1:0] click_time_in;
   logic [TIME_W-1:0] held;
   logic [TIME_W-1:0] age_old;
   logic [TIME_W-1:0] age_new;
   logic [TIME_W-1:0] long_ext;
   logic [TIME_W-1:0] service_ext;
   logic [TIME_W-1:0] window_ext;

   assign held        = now_ms - press_start_ff;
   assign age_old     = now_ms - click_time_ff;
   assign age_new     = now_ms - click_time_in;
   assign long_ext    = {{(TIME_W-CFG_W){1'b0}}, long_press_ms};
   assign service_ext = {{(TIME_W-CFG_W){1'b0}}, service_min_ms};
   assign window_ext  = {{(TIME_W-CFG_W){1'b0}}, click_window_ms};

   always_comb begin
      press_start_in   = press_start_ff;
      click_pending_in = click_pending_ff;
      click_time_in    = click_time_ff;
      events           = '0;
      if (button.changed) begin
         if (!button.level) begin
            press_start_in = now_ms;
         end else if (held >= service_ext) begin
            click_pending_in    = 1'b0;
            events.service_hold = 1'b1;
         end else if (held >= long_ext) begin
            click_pending_in  = 1'b0;
            events.long_press = 1'b1;
         end else if (click_pending_ff && (age_old <= window_ext)) begin
            click_pending_in    = 1'b0;
            events.double_click = 1'b1;
         end else begin
            events.single_click = click_pending_ff;
            click_pending_in    = 1'b1;
            click_time_in       = now_ms;
         end
      end
      if (button.level && click_pending_in && (age_new > window_ext)) begin
         click_pending_in    = 1'b0;
         events.single_click = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_start_ff   <= '0;
         click_pending_ff <= 1'b0;
         click_time_ff    <= '0;
      end else if (advance) begin
         press_start_ff   <= press_start_in;
         click_pending_ff <= click_pending_in;
         click_time_ff    <= click_time_in;
      end
   end

endmodule

// ----- bench/button_gesture_debouncer_core_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button gesture debouncer - response checker
// Watches the request, response and register ports. Each accepted request
// runs through an independent debounce and gesture classifier, and the flags
// it yields are queued. Each accepted response is compared field by field
// with the oldest queued flags.
// ---------------------------------------------------------------------------

module button_gesture_debouncer_core_checker
   import bgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic              req_button_level,
   input  logic              req_blade_level,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_blade_inserted,
   input  logic              rsp_blade_removed,
   input  logic              rsp_single_click,
   input  logic              rsp_double_click,
   input  logic              rsp_long_press,
   input  logic              rsp_service_hold,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   input  logic              pready,
   output int                mismatches,
   output int                pending_polls
);

   typedef struct packed {
      logic blade_inserted;
      logic blade_removed;
      logic single_click;
      logic double_click;
      logic long_press;
      logic service_hold;
   } gesture_flags_type;

   logic [CFG_W-1:0]  debounce_ms;
   logic [CFG_W-1:0]  long_press_ms;
   logic [CFG_W-1:0]  service_min_ms;
   logic [CFG_W-1:0]  click_window_ms;

   logic              blade_raw;
   logic              blade_stable;
   logic [TIME_W-1:0] blade_since;
   logic              button_raw;
   logic              button_stable;
   logic [TIME_W-1:0] button_since;
   logic [TIME_W-1:0] press_start;
   logic              click_waiting;
   logic [TIME_W-1:0] click_at;

   gesture_flags_type flags_due[$];
   int                fail_count = 0;

   task automatic classify_poll(input logic [TIME_W-1:0] now, input logic btn,
                                input logic blade, output gesture_flags_type f);
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] held;
      f = '0;

      if (blade != blade_raw) begin
         blade_raw   = blade;
         blade_since = now;
      end
      age = now - blade_since;
      if (blade != blade_stable && age >= TIME_W'(debounce_ms)) begin
         blade_stable     = blade;
         f.blade_inserted = !blade;
         f.blade_removed  = blade;
      end

      if (btn != button_raw) begin
         button_raw   = btn;
         button_since = now;
      end
      age = now - button_since;
      if (btn != button_stable && age >= TIME_W'(debounce_ms)) begin
         button_stable = btn;
         if (!btn) begin
            press_start = now;
         end else begin
            held = now - press_start;
            age  = now - click_at;
            if (held >= TIME_W'(service_min_ms)) begin
               click_waiting  = 1'b0;
               f.service_hold = 1'b1;
            end else if (held >= TIME_W'(long_press_ms)) begin
               click_waiting = 1'b0;
               f.long_press  = 1'b1;
            end else if (click_waiting && age <= TIME_W'(click_window_ms)) begin
               click_waiting  = 1'b0;
               f.double_click = 1'b1;
            end else begin
               if (click_waiting) f.single_click = 1'b1;
               click_waiting = 1'b1;
               click_at      = now;
            end
         end
      end

      age = now - click_at;
      if (button_stable && click_waiting && age > TIME_W'(click_window_ms)) begin
         click_waiting  = 1'b0;
         f.single_click = 1'b1;
      end
   endtask

   always @(posedge clock) begin : monitor
      gesture_flags_type due;
      gesture_flags_type seen;
      if (reset) begin
         debounce_ms     = DEBOUNCE_RST;
         long_press_ms   = LONG_PRESS_RST;
         service_min_ms  = SERVICE_HOLD_RST;
         click_window_ms = DOUBLE_CLICK_RST;
         blade_raw       = 1'b1;
         blade_stable    = 1'b1;
         blade_since     = '0;
         button_raw      = 1'b1;
         button_stable   = 1'b1;
         button_since    = '0;
         press_start     = '0;
         click_waiting   = 1'b0;
         click_at        = '0;
         flags_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_blade_inserted, rsp_blade_removed, rsp_single_click,
                     rsp_double_click, rsp_long_press, rsp_service_hold};
            if (flags_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request waiting, flags %b",
                           $time, seen);
            end else begin
               due = flags_due.pop_front();
               if (seen.blade_inserted !== due.blade_inserted ||
                   seen.blade_removed  !== due.blade_removed  ||
                   seen.single_click   !== due.single_click   ||
                   seen.double_click   !== due.double_click   ||
                   seen.long_press     !== due.long_press     ||
                   seen.service_hold   !== due.service_hold) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: ins/rem/single/double/long/service expected %b got %b",
                              $time, due, seen);
               end
            end
         end

         if (req_valid && req_ready) begin
            classify_poll(req_now_ms, req_button_level, req_blade_level, due);
            flags_due.push_back(due);
         end

         if (psel && penable && pwrite && pready) begin
            case (bgd_reg_type'(paddr[ADDR_W-1:2]))
               REG_DEBOUNCE:     debounce_ms     = pwdata[CFG_W-1:0];
               REG_LONG_PRESS:   long_press_ms   = pwdata[CFG_W-1:0];
               REG_SERVICE_HOLD: service_min_ms  = pwdata[CFG_W-1:0];
               REG_DOUBLE_CLICK: click_window_ms = pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
      end
      mismatches    <= fail_count;
      pending_polls <= flags_due.size();
   end

endmodule

// ----- bench/button_gesture_debouncer_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button gesture debouncer - testbench top
// Drives polls shaped as clicks, double clicks, long presses, service holds,
// blade changes and contact bounce, plus random noise, across several timing
// register settings, with random idle gaps on both channels. The checker
// beside the block reports mismatches; this module gives the verdict.
// ---------------------------------------------------------------------------

module button_gesture_debouncer_core_test;
   import bgd_pkg::*;

   localparam int unsigned POLL_TOTAL = 1450;
   localparam int unsigned PHASES     = 9;
   localparam logic [TIME_W-1:0] WRAP_BASE = 32'hFFFF_FF00;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [TIME_W-1:0] req_now_ms       = '0;
   logic              req_button_level = 1'b1;
   logic              req_blade_level  = 1'b1;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic              rsp_blade_inserted;
   logic              rsp_blade_removed;
   logic              rsp_single_click;
   logic              rsp_double_click;
   logic              rsp_long_press;
   logic              rsp_service_hold;
   logic              psel             = 1'b0;
   logic              penable          = 1'b0;
   logic              pwrite           = 1'b0;
   logic [ADDR_W-1:0] paddr            = '0;
   logic [CSR_W-1:0]  pwdata           = '0;
   logic [CSR_W-1:0]  prdata;
   logic              pready;

   int                mismatches;
   int                pending_polls;

   logic [TIME_W-1:0] now_ms;
   logic              button_raw;
   logic              blade_raw;
   int unsigned       polls_sent      = 0;
   logic              steady_sender   = 1'b0;
   logic              steady_receiver = 1'b0;
   int unsigned       stall_left      = 0;
   logic [CFG_W-1:0]  cfg_debounce    = DEBOUNCE_RST;
   logic [CFG_W-1:0]  cfg_long        = LONG_PRESS_RST;
   logic [CFG_W-1:0]  cfg_service     = SERVICE_HOLD_RST;
   logic [CFG_W-1:0]  cfg_double      = DOUBLE_CLICK_RST;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   button_gesture_debouncer_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .req_button_level   (req_button_level),
      .req_blade_level    (req_blade_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blade_inserted (rsp_blade_inserted),
      .rsp_blade_removed  (rsp_blade_removed),
      .rsp_single_click   (rsp_single_click),
      .rsp_double_click   (rsp_double_click),
      .rsp_long_press     (rsp_long_press),
      .rsp_service_hold   (rsp_service_hold),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   button_gesture_debouncer_core_checker gesture_chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .req_button_level   (req_button_level),
      .req_blade_level    (req_blade_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blade_inserted (rsp_blade_inserted),
      .rsp_blade_removed  (rsp_blade_removed),
      .rsp_single_click   (rsp_single_click),
      .rsp_double_click   (rsp_double_click),
      .rsp_long_press     (rsp_long_press),
      .rsp_service_hold   (rsp_service_hold),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .mismatches         (mismatches),
      .pending_polls      (pending_polls)
   );

   // stall the response side: short stalls mostly, a few long, steady stretches
   always @(negedge clock) begin : receiver
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (roll < 2)
            steady_receiver <= !steady_receiver;
         else if (!steady_receiver && roll < 22)
            stall_left <= $urandom_range(1, 3);
         else if (!steady_receiver && roll < 25)
            stall_left <= $urandom_range(10, 40);
      end
   end

   function automatic int unsigned sender_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_sender || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned around(int unsigned v);
      case ($urandom_range(0, 3))
         0:       return (v == 0) ? 0 : v - 1;
         1:       return v;
         2:       return v + 1;
         default: return $urandom_range(0, v + v / 2 + 1);
      endcase
   endfunction

   function automatic int unsigned short_hold();
      return $urandom_range(0, (cfg_long == 0) ? 0 : int'(cfg_long) - 1);
   endfunction

   task automatic send_poll();
      int unsigned gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_now_ms       <= now_ms;
      req_button_level <= button_raw;
      req_blade_level  <= blade_raw;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
   endtask

   task automatic poll_at(int unsigned dt, logic btn, logic blade);
      now_ms     = now_ms + dt;
      button_raw = btn;
      blade_raw  = blade;
      send_poll();
   endtask

   task automatic poll_abs(logic [TIME_W-1:0] t, logic btn, logic blade);
      now_ms = t;
      poll_at(0, btn, blade);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_polls != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(bgd_reg_type idx, logic [CFG_W-1:0] v);
      logic [CSR_W-CFG_W-1:0] junk;
      junk = (CSR_W-CFG_W)'($urandom);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= {junk, v};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_timing(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng,
                             logic [CFG_W-1:0] svc, logic [CFG_W-1:0] dbl);
      drain();
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_LONG_PRESS, lng);
      write_reg(REG_SERVICE_HOLD, svc);
      write_reg(REG_DOUBLE_CLICK, dbl);
      cfg_debounce = deb;
      cfg_long     = lng;
      cfg_service  = svc;
      cfg_double   = dbl;
   endtask

   task automatic chatter_button();
      repeat ($urandom_range(0, 3))
         poll_at($urandom_range(0, cfg_debounce / 2), 1'($urandom_range(0, 1)), blade_raw);
   endtask

   task automatic press_button(int unsigned hold);
      int unsigned rest;
      int unsigned step;
      chatter_button();
      poll_at($urandom_range(0, 5), 1'b0, blade_raw);
      poll_at(around(cfg_debounce), 1'b0, blade_raw);
      rest = hold;
      repeat ($urandom_range(0, 2)) begin
         step = $urandom_range(0, rest);
         poll_at(step, 1'b0, blade_raw);
         rest = rest - step;
      end
      chatter_button();
      poll_at(rest, 1'b1, blade_raw);
      poll_at(around(cfg_debounce), 1'b1, blade_raw);
   endtask

   task automatic random_gesture();
      int unsigned kind;
      logic        flip_button;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) steady_sender = !steady_sender;
      if (kind < 28) begin
         press_button(short_hold());
      end else if (kind < 48) begin
         press_button(short_hold());
         now_ms = now_ms + around($urandom_range(0, cfg_double));
         press_button($urandom_range(0, short_hold() / 4));
      end else if (kind < 58) begin
         if ($urandom_range(0, 1)) press_button(around(cfg_long));
         else press_button($urandom_range(cfg_long, cfg_service + 1));
      end else if (kind < 65) begin
         press_button(around(cfg_service));
      end else if (kind < 76) begin
         flip_button = ($urandom_range(0, 9) < 3);
         repeat ($urandom_range(0, 3))
            poll_at($urandom_range(0, cfg_debounce / 2), button_raw,
                    1'($urandom_range(0, 1)));
         poll_at($urandom_range(0, 5), button_raw ^ flip_button, !blade_raw);
         poll_at(around(cfg_debounce), button_raw, blade_raw);
      end else if (kind < 86) begin
         repeat ($urandom_range(1, 2))
            poll_at(around(cfg_double), button_raw, blade_raw);
      end else begin
         repeat ($urandom_range(1, 4)) begin
            now_ms     = $urandom;
            button_raw = 1'($urandom_range(0, 1));
            blade_raw  = 1'($urandom_range(0, 1));
            send_poll();
         end
      end
   endtask

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned waited;
      logic        paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default timing, times crossing the counter wrap
      poll_abs(WRAP_BASE + 0,    1'b1, 1'b1);
      poll_abs(WRAP_BASE + 0,    1'b1, 1'b0);
      poll_abs(WRAP_BASE + 29,   1'b1, 1'b0);
      poll_abs(WRAP_BASE + 30,   1'b1, 1'b0);
      poll_abs(WRAP_BASE + 40,   1'b0, 1'b0);
      poll_abs(WRAP_BASE + 70,   1'b0, 1'b0);
      poll_abs(WRAP_BASE + 100,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 130,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 200,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 230,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 255,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 256,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 285,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 300,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 330,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 340,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 370,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 400,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 430,  1'b0, 1'b0);
      poll_abs(WRAP_BASE + 800,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 830,  1'b1, 1'b0);
      poll_abs(WRAP_BASE + 1181, 1'b1, 1'b1);
      poll_abs(WRAP_BASE + 1211, 1'b1, 1'b1);
      poll_abs(WRAP_BASE + 1300, 1'b0, 1'b1);
      poll_abs(WRAP_BASE + 1330, 1'b0, 1'b1);
      poll_abs(WRAP_BASE + 2130, 1'b1, 1'b1);
      poll_abs(WRAP_BASE + 2160, 1'b1, 1'b1);
      poll_abs(WRAP_BASE + 2200, 1'b0, 1'b1);
      poll_abs(WRAP_BASE + 2230, 1'b0, 1'b1);
      poll_abs(WRAP_BASE + 7230, 1'b1, 1'b1);
      poll_abs(WRAP_BASE + 7260, 1'b1, 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;
            1: set_timing(16'd0, 16'd200, 16'd600, 16'd100);
            2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: set_timing(16'd0, 16'd0, 16'd0, 16'd0);
            4: set_timing(16'd5, 16'd300, 16'd1000, 16'd150);
            default: begin
               if ($urandom_range(0, 3) == 0)
                  set_timing(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom),
                             CFG_W'($urandom), CFG_W'($urandom));
               else
                  set_timing(CFG_W'($urandom_range(0, 40)),
                             CFG_W'($urandom_range(0, 1500)),
                             CFG_W'($urandom_range(0, 4000)),
                             CFG_W'($urandom_range(0, 500)));
            end
         endcase
         while (polls_sent < (phase + 1) * POLL_TOTAL / PHASES) begin
            if (!paused && polls_sent >= POLL_TOTAL / 2) begin
               drain();
               paused = 1'b1;
            end
            random_gesture();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_polls != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);

      if (mismatches == 0 && pending_polls == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
